/* design/nrvd_pkg.sv */
// ----------------------------------------------------------------------------
// nrvd_pkg
// Shared types and constants for the n-gram record varint decoder.
// ----------------------------------------------------------------------------
package nrvd_pkg;

    localparam int TOKEN_BITS   = 31;
    localparam int MAX_ORDER    = 15;
    localparam int FREQ_BITS    = 15;
    localparam int INDEX_BITS   = 4;
    localparam int PAYLOAD_BITS = 7;
    localparam int STATUS_BITS  = 3;
    localparam int OUT_DATA_BITS = 56;

    localparam logic [INDEX_BITS-1:0] MAX_ORDER_W = INDEX_BITS'(MAX_ORDER);

    typedef enum logic [1:0]
    {
        CMD_DATA    = 2'd0,
        CMD_SEG_END = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [1:0]
    {
        PH_FREQ    = 2'd0,
        PH_TOKENS  = 2'd1,
        PH_STOPPED = 2'd2,
        PH_HALTED  = 2'd3
    } phase_t;

    typedef enum logic [STATUS_BITS-1:0]
    {
        ST_TOKEN     = 3'd0,
        ST_LOW_FREQ  = 3'd1,
        ST_FREQ_OVF  = 3'd2,
        ST_TOKEN_OVF = 3'd3,
        ST_EARLY_END = 3'd4
    } status_t;

    typedef enum logic [1:0]
    {
        REG_FLOOR_FREQ = 2'd0,
        REG_MAX_FREQ   = 2'd1,
        REG_TOKENS_PER = 2'd2
    } reg_idx_t;

    typedef struct packed
    {
        status_t                 status;
        logic [FREQ_BITS-1:0]    record_freq;
        logic [TOKEN_BITS-1:0]   token_id;
        logic [INDEX_BITS-1:0]   token_index;
        logic                    last_token;
    } result_t;

endpackage

/* design/nrvd_out_skid.sv */
// ----------------------------------------------------------------------------
// nrvd_out_skid
// Output register plus one skid entry for decoded result beats.
// ----------------------------------------------------------------------------
module nrvd_out_skid
    import nrvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  result_t in_res,
    output logic    in_ready,
    output logic    out_valid,
    output result_t out_res,
    input  logic    out_ready
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_res_reg;
    result_t skid_res_reg;
    logic    out_load;

    // a result only arrives on an accepted beat, so never while skid is full
    assign in_ready  = !skid_valid_reg;
    assign out_load  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg  <= skid_valid_reg || in_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (in_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : in_res;
        end
        else if (in_valid)
        begin
            skid_res_reg <= in_res;
        end
    end

endmodule

/* design/ngram_record_varint_decoder.sv */
// ----------------------------------------------------------------------------
// ngram_record_varint_decoder
// Decodes a varint byte stream of n-gram records into per-token beats.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake                     | payload
//  ---------+-----+-------------------------------+------------------------------
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser: cmd, tdata: data_byte
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tuser: status, tlast: last,
//           |     |                               | tdata: freq, token, index
//  cfg      | in  | cfg_we (no wait)              | cfg_index, cfg_data
//
// One input beat per cycle while s_axis_tready is high. Each beat is decoded
// in the cycle it is accepted: the accumulators shift in seven payload bits
// and compares decide the result, which is registered in the output or skid entry.
// The output register plus a skid entry let input keep flowing while a result
// waits; s_axis_tready drops only when both hold a result.
// Reset clears the decoder state and loads a frequency floor of 1, max_freq
// 32767 and one token per record.
module ngram_record_varint_decoder
    import nrvd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [7:0]               s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]               s_axis_tuser,   // [1:0] cmd

    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // [14:0] record_freq,
                                                     // [45:15] token_id,
                                                     // [49:46] token_index, zero pad
    output logic [STATUS_BITS-1:0]   m_axis_tuser,   // [2:0] status
    output logic                     m_axis_tlast,   // last_token

    input  logic                     cfg_we,
    input  logic [1:0]               cfg_index,
    input  logic [FREQ_BITS-1:0]     cfg_data
);

    localparam int FREQ_WIDE = FREQ_BITS + PAYLOAD_BITS;

    // configuration registers
    logic [FREQ_BITS-1:0]  floor_freq_reg;
    logic [FREQ_BITS-1:0]  max_freq_reg;
    logic [INDEX_BITS-1:0] tokens_per_reg;

    // decoder state; the frequency accumulator is only loaded with values not above max_freq
    phase_t                phase_reg,       phase_next;
    logic [FREQ_BITS-1:0]  freq_accum_reg,  freq_accum_next;
    logic [FREQ_BITS-1:0]  held_freq_reg,   held_freq_next;
    logic [TOKEN_BITS-1:0] token_accum_reg, token_accum_next;
    logic [INDEX_BITS-1:0] tokens_done_reg, tokens_done_next;

    logic                  accept;
    cmd_t                  cmd;
    logic [PAYLOAD_BITS-1:0] payload;
    logic                  more;
    logic [FREQ_WIDE-1:0]  freq_shift;
    logic [TOKEN_BITS-1:0] token_shift;
    logic [INDEX_BITS-1:0] record_len;
    logic                  is_last;
    logic                  res_valid;
    result_t               res;
    result_t               out_res;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign cmd         = cmd_t'(s_axis_tuser);
    assign payload     = s_axis_tdata[PAYLOAD_BITS-1:0];
    assign more        = s_axis_tdata[7];
    assign freq_shift  = {freq_accum_reg, payload};
    assign token_shift = {token_accum_reg[TOKEN_BITS-PAYLOAD_BITS-1:0], payload};

    // a zero record length acts as one; the 4-bit field cannot exceed the max order
    assign record_len = (tokens_per_reg == '0) ? INDEX_BITS'(1) :
                        (tokens_per_reg > MAX_ORDER_W) ? MAX_ORDER_W : tokens_per_reg;
    assign is_last    = ({1'b0, tokens_done_reg} + 5'd1) >= {1'b0, record_len};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_freq_reg <= FREQ_BITS'(1);
            max_freq_reg   <= '1;
            tokens_per_reg <= INDEX_BITS'(1);
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_FLOOR_FREQ: floor_freq_reg <= cfg_data;
                REG_MAX_FREQ:   max_freq_reg   <= cfg_data;
                REG_TOKENS_PER: tokens_per_reg <= cfg_data[INDEX_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_FREQ;
            freq_accum_reg  <= '0;
            held_freq_reg   <= '0;
            token_accum_reg <= '0;
            tokens_done_reg <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            freq_accum_reg  <= freq_accum_next;
            held_freq_reg   <= held_freq_next;
            token_accum_reg <= token_accum_next;
            tokens_done_reg <= tokens_done_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        freq_accum_next  = freq_accum_reg;
        held_freq_next   = held_freq_reg;
        token_accum_next = token_accum_reg;
        tokens_done_next = tokens_done_reg;
        res_valid        = 1'b0;
        res              = '0;

        if (accept)
        begin
            case (cmd)
                CMD_RESTART:
                begin
                    // clear everything but the configuration
                    phase_next       = PH_FREQ;
                    freq_accum_next  = '0;
                    held_freq_next   = '0;
                    token_accum_next = '0;
                    tokens_done_next = '0;
                end

                CMD_SEG_END:
                begin
                    case (phase_reg)
                        PH_FREQ:
                        begin
                            // a segment may end cleanly between records
                            if (freq_accum_reg != '0)
                            begin
                                phase_next = PH_HALTED;
                                res_valid  = 1'b1;
                                res.status = ST_EARLY_END;
                            end
                        end
                        PH_TOKENS:
                        begin
                            phase_next      = PH_HALTED;
                            res_valid       = 1'b1;
                            res.status      = ST_EARLY_END;
                            res.record_freq = held_freq_reg;
                        end
                        default: ;
                    endcase
                end

                CMD_DATA:
                begin
                    case (phase_reg)
                        PH_FREQ:
                        begin
                            if (freq_shift > {{PAYLOAD_BITS{1'b0}}, max_freq_reg})
                            begin
                                phase_next = PH_HALTED;
                                res_valid  = 1'b1;
                                res.status = ST_FREQ_OVF;
                            end
                            else if (more)
                            begin
                                freq_accum_next = freq_shift[FREQ_BITS-1:0];
                            end
                            else
                            begin
                                // frequency complete: hold it for the tokens
                                held_freq_next  = freq_shift[FREQ_BITS-1:0];
                                freq_accum_next = '0;
                                if (freq_shift[FREQ_BITS-1:0] < floor_freq_reg)
                                begin
                                    phase_next      = PH_STOPPED;
                                    res_valid       = 1'b1;
                                    res.status      = ST_LOW_FREQ;
                                    res.record_freq = freq_shift[FREQ_BITS-1:0];
                                end
                                else
                                begin
                                    phase_next       = PH_TOKENS;
                                    tokens_done_next = '0;
                                    token_accum_next = '0;
                                end
                            end
                        end

                        PH_TOKENS:
                        begin
                            // any of the top seven bits set means this byte's shift would overflow
                            if (token_accum_reg[TOKEN_BITS-1:TOKEN_BITS-PAYLOAD_BITS] != '0)
                            begin
                                phase_next      = PH_HALTED;
                                res_valid       = 1'b1;
                                res.status      = ST_TOKEN_OVF;
                                res.record_freq = held_freq_reg;
                            end
                            else if (more)
                            begin
                                token_accum_next = token_shift;
                            end
                            else
                            begin
                                res_valid        = 1'b1;
                                res.status       = ST_TOKEN;
                                res.record_freq  = held_freq_reg;
                                res.token_id     = token_shift;
                                res.token_index  = tokens_done_reg;
                                res.last_token   = is_last;
                                token_accum_next = '0;
                                if (is_last)
                                begin
                                    tokens_done_next = '0;
                                    phase_next       = PH_FREQ;
                                end
                                else
                                begin
                                    tokens_done_next = tokens_done_reg + INDEX_BITS'(1);
                                end
                            end
                        end

                        // stopped or halted: drop the byte
                        default: ;
                    endcase
                end

                default: ;
            endcase
        end
    end

    nrvd_out_skid u_out_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_res    (res),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_res   (out_res),
        .out_ready (m_axis_tready)
    );

    assign m_axis_tuser = out_res.status;
    assign m_axis_tlast = out_res.last_token;
    assign m_axis_tdata = {
        {(OUT_DATA_BITS - FREQ_BITS - TOKEN_BITS - INDEX_BITS){1'b0}},
        out_res.token_index,
        out_res.token_id,
        out_res.record_freq
    };

endmodule
